// ----- sv/lkvc_pkg.sv -----
// Shared constants, codes and structs for the LRU key/value cache.
// Used by lkvc_store, lkvc_ctrl and lru_key_value_cache_core; no dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int CAPACITY   = 10;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IN_DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // update request to the slot chain: slots 1..pos take their neighbor, slot 0 the new entry
    typedef struct packed {
        logic                  upd;
        logic                  ins;
        logic [IDX_W-1:0]      pos;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_store_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic                  full;
        logic                  match;
        logic [VALUE_BITS-1:0] rd_value;
    } t_store_stat;

    typedef struct packed {
        logic                  load;
        logic                  found;
        logic [VALUE_BITS-1:0] value;
        logic                  evicted;
    } t_result;

endpackage

// ----- sv/lkvc_store.sv -----
// Recency-ordered slot chain with entry count and the shared key comparator.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkvc_pkg::t_store_cmd      i_cmd,
    input  logic [lkvc_pkg::CNT_W-1:0] i_rd_idx,
    input  logic [lkvc_pkg::KEY_BITS-1:0] i_cmp_key,
    output lkvc_pkg::t_store_stat     o_stat
);

    logic [lkvc_pkg::KEY_BITS-1:0]   r_key [lkvc_pkg::CAPACITY];
    logic [lkvc_pkg::VALUE_BITS-1:0] r_val [lkvc_pkg::CAPACITY];
    logic [lkvc_pkg::CNT_W-1:0]      r_count;
    logic [lkvc_pkg::CNT_W-1:0]      n_count;
    logic                            w_full;
    logic                            w_in_range;
    logic [lkvc_pkg::IDX_W-1:0]      w_slot;

    assign w_full     = (r_count == lkvc_pkg::CNT_W'(lkvc_pkg::CAPACITY));
    assign w_in_range = (i_rd_idx < r_count);
    assign w_slot     = i_rd_idx[lkvc_pkg::IDX_W-1:0];

    // one compare per cycle against the slot under the scan index
    always_comb begin
        o_stat.count    = r_count;
        o_stat.full     = w_full;
        o_stat.match    = w_in_range && (r_key[w_slot] == i_cmp_key);
        o_stat.rd_value = r_val[w_slot];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.upd && i_cmd.ins && !w_full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_key[0] <= i_cmd.key;
            r_val[0] <= i_cmd.value;
            for (int i = 1; i < lkvc_pkg::CAPACITY; i++) begin
                if (lkvc_pkg::IDX_W'(i) <= i_cmd.pos) begin
                    r_key[i] <= r_key[i-1];
                    r_val[i] <= r_val[i-1];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lkvc_pkg::CNT_W'(lkvc_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_front_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> (r_key[0] == $past(i_cmd.key)) && (r_val[0] == $past(i_cmd.value)))
        else $error("front slot not loaded on update");

    a_move_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && !i_cmd.ins) |=> $stable(r_count))
        else $error("count changed on move to front");

endmodule

// ----- sv/lkvc_ctrl.sv -----
// Sequencer: latches a request, walks the shared comparator over the slots for a lookup,
// then issues the result word and, for an insert or a hit, the chain update. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lkvc_pkg::t_op                 i_req_op,
    input  logic [lkvc_pkg::KEY_BITS-1:0] i_req_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0] i_req_value,
    input  logic                          i_out_free,
    input  lkvc_pkg::t_store_stat         i_stat,
    output lkvc_pkg::t_store_cmd          o_cmd,
    output logic [lkvc_pkg::CNT_W-1:0]    o_rd_idx,
    output logic [lkvc_pkg::KEY_BITS-1:0] o_cmp_key,
    output lkvc_pkg::t_result             o_result
);

    lkvc_pkg::t_state                r_state, n_state;
    lkvc_pkg::t_op                   r_op, n_op;
    logic [lkvc_pkg::KEY_BITS-1:0]   r_key, n_key;
    logic [lkvc_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic [lkvc_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                            r_hit, n_hit;
    logic [lkvc_pkg::IDX_W-1:0]      r_pos, n_pos;
    logic                            w_accept;
    logic                            w_scan_end;

    assign w_accept   = i_req_valid && o_req_ready;
    assign w_scan_end = (r_idx == i_stat.count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_op == lkvc_pkg::OP_INSERT) ? lkvc_pkg::ST_DONE
                                                                : lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN: begin
                if (w_scan_end || i_stat.match) begin
                    n_state = lkvc_pkg::ST_DONE;
                end
            end
            lkvc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = lkvc_pkg::ST_IDLE;
                end
            end
            default: n_state = lkvc_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath registers
    always_comb begin
        o_req_ready = 1'b0;
        o_rd_idx    = r_idx;
        o_cmp_key   = r_key;
        o_cmd       = '0;
        o_result    = '0;
        n_op  = r_op;
        n_key = r_key;
        n_val = r_val;
        n_idx = r_idx;
        n_hit = r_hit;
        n_pos = r_pos;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (w_accept) begin
                    n_op  = i_req_op;
                    n_key = i_req_key;
                    n_val = i_req_value;
                    n_idx = '0;
                    n_hit = 1'b0;
                    n_pos = '0;
                end
            end
            lkvc_pkg::ST_SCAN: begin
                if (!w_scan_end) begin
                    if (i_stat.match) begin
                        n_hit = 1'b1;
                        n_pos = r_idx[lkvc_pkg::IDX_W-1:0];
                        n_val = i_stat.rd_value;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            lkvc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.upd     = (r_op == lkvc_pkg::OP_INSERT) || r_hit;
                    o_cmd.ins     = (r_op == lkvc_pkg::OP_INSERT);
                    o_cmd.pos     = (r_op == lkvc_pkg::OP_INSERT)
                                  ? lkvc_pkg::IDX_W'(lkvc_pkg::CAPACITY - 1) : r_pos;
                    o_cmd.key     = r_key;
                    o_cmd.value   = r_val;
                    o_result.load = 1'b1;
                    o_result.found   = (r_op == lkvc_pkg::OP_LOOKUP) && r_hit;
                    o_result.value   = ((r_op == lkvc_pkg::OP_LOOKUP) && r_hit) ? r_val : '0;
                    o_result.evicted = (r_op == lkvc_pkg::OP_INSERT) && i_stat.full;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_val <= n_val;
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_pos <= n_pos;
    end

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkvc_pkg::ST_SCAN) |-> (r_idx <= i_stat.count))
        else $error("scan index ran past entry count");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.load |-> i_out_free)
        else $error("result issued while output word occupied");

    a_hit_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.load |-> !(o_result.found && o_result.evicted))
        else $error("result flags both found and evicted");

endmodule

// ----- sv/lru_key_value_cache_core.sv -----
// Lookup: the shared comparator scans from slot 0 (most recent) to a hit in slot p,
// or over all count entries on a miss; result valid and ready rise together.
// Insert skips the scan. One request at a time; the comparator steps one slot a cycle.
// Synchronous active-low reset empties the cache (count cleared) and the output register.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_store.
`timescale 1ns / 1ps

module lru_key_value_cache_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [lkvc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // key_id, entry_value
    input  logic                             i_s_axis_tuser,  // operation
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [lkvc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // found_value
    output logic [1:0]                       o_m_axis_tuser   // found, evicted
);

    lkvc_pkg::t_store_cmd            w_cmd;
    lkvc_pkg::t_store_stat           w_stat;
    lkvc_pkg::t_result               w_result;
    logic [lkvc_pkg::CNT_W-1:0]      w_rd_idx;
    logic [lkvc_pkg::KEY_BITS-1:0]   w_cmp_key;
    logic                            w_out_free;

    logic                            r_out_valid;
    logic                            r_found;
    logic [lkvc_pkg::VALUE_BITS-1:0] r_found_value;
    logic                            r_evicted;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_op    (lkvc_pkg::t_op'(i_s_axis_tuser)),
        .i_req_key   (i_s_axis_tdata[lkvc_pkg::KEY_BITS-1:0]),
        .i_req_value (i_s_axis_tdata[lkvc_pkg::KEY_BITS +: lkvc_pkg::VALUE_BITS]),
        .i_out_free  (w_out_free),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_idx    (w_rd_idx),
        .o_cmp_key   (w_cmp_key),
        .o_result    (w_result)
    );

    lkvc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_idx  (w_rd_idx),
        .i_cmp_key (w_cmp_key),
        .o_stat    (w_stat)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.load) begin
            r_found       <= w_result.found;
            r_found_value <= w_result.value;
            r_evicted     <= w_result.evicted;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = lkvc_pkg::OUT_DATA_W'(r_found_value);
    assign o_m_axis_tuser  = {r_evicted, r_found};

endmodule
